@@ design/vsae_pkg.sv @@
// Shared constants and arctangent table for the velocity to speed/azimuth/elevation block.
`default_nettype none

package vsae_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ANG_W     = 32;
  localparam int ANG_SHIFT = 16;
  localparam int TABLE_LEN = 24;
  localparam int AZ_W      = 15;
  localparam int EL_W      = 13;
  localparam int SPEED_W   = 16;

  // angles in units of 2^-22 degree
  localparam logic signed [ANG_W-1:0] ANG_180  = 32'sd754974720;
  localparam logic signed [ANG_W-1:0] ANG_360  = 32'sd1509949440;
  localparam logic signed [ANG_W-1:0] ANG_HALF = 32'sd32768;

  localparam logic [AZ_W-1:0]    AZ_FULL   = 15'd23040;
  localparam logic [EL_W-1:0]    EL_MAX    = 13'd5760;
  localparam logic [SPEED_W-1:0] SPEED_MAX = 16'hFFFF;

  // 1/K in Q32
  localparam logic [31:0] GAIN_INV = 32'd2608131496;
  localparam logic [63:0] GAIN_RND = 64'h0000_0000_8000_0000;

  // atan(2^-i), 2^-22 degree units
  localparam logic signed [ANG_W-1:0] ATAN_TAB [TABLE_LEN] = '{
    32'sd188743680, 32'sd111421900, 32'sd58872272, 32'sd29884485,
    32'sd15000234,  32'sd7507429,   32'sd3754631,  32'sd1877430,
    32'sd938729,    32'sd469366,    32'sd234683,   32'sd117342,
    32'sd58671,     32'sd29335,     32'sd14668,    32'sd7334,
    32'sd3667,      32'sd1833,      32'sd917,      32'sd458,
    32'sd229,       32'sd115,       32'sd57,       32'sd29
  };

endpackage

`default_nettype wire

@@ design/vsae_cordic_step.sv @@
// One registered CORDIC vectoring iteration.
`default_nettype none

module vsae_cordic_step import vsae_pkg::*; #(
  parameter int DW  = 34,
  parameter int IDX = 0,
  parameter int SW  = 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  v_in,
  input  wire logic signed [DW-1:0]  x_in,
  input  wire logic signed [DW-1:0]  y_in,
  input  wire logic signed [ANG_W-1:0] z_in,
  input  wire logic [SW-1:0]         side_in,
  output logic                       v_out,
  output logic signed [DW-1:0]       x_out,
  output logic signed [DW-1:0]       y_out,
  output logic signed [ANG_W-1:0]    z_out,
  output logic [SW-1:0]              side_out
);

  logic signed [DW-1:0]    xs, ys, x_nxt, y_nxt;
  logic signed [ANG_W-1:0] z_nxt;
  logic                    v_r;
  logic signed [DW-1:0]    x_r, y_r;
  logic signed [ANG_W-1:0] z_r;
  logic [SW-1:0]           side_r;

  always_comb begin
    xs = x_in >>> IDX;
    ys = y_in >>> IDX;
    if (!y_in[DW-1]) begin
      x_nxt = x_in + ys;
      y_nxt = y_in - xs;
      z_nxt = z_in + ATAN_TAB[IDX];
    end else begin
      x_nxt = x_in - ys;
      y_nxt = y_in + xs;
      z_nxt = z_in - ATAN_TAB[IDX];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    side_r <= side_in;
  end

  assign v_out    = v_r;
  assign x_out    = x_r;
  assign y_out    = y_r;
  assign z_out    = z_r;
  assign side_out = side_r;

endmodule

`default_nettype wire

@@ design/vsae_cordic_pass.sv @@
// Unrolled CORDIC vectoring pass, one register stage per iteration.
`default_nettype none

module vsae_cordic_pass import vsae_pkg::*; #(
  parameter int DW    = 34,
  parameter int NSTEP = 16,
  parameter int SW    = 1
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    v_in,
  input  wire logic signed [DW-1:0]    x_in,
  input  wire logic signed [DW-1:0]    y_in,
  input  wire logic signed [ANG_W-1:0] z_in,
  input  wire logic [SW-1:0]           side_in,
  output logic                         v_out,
  output logic signed [DW-1:0]         x_out,
  output logic signed [ANG_W-1:0]      z_out,
  output logic [SW-1:0]                side_out
);

  logic                    va [NSTEP+1];
  logic signed [DW-1:0]    xa [NSTEP+1];
  logic signed [DW-1:0]    ya [NSTEP];
  logic signed [ANG_W-1:0] za [NSTEP+1];
  logic [SW-1:0]           sa [NSTEP+1];

  assign va[0] = v_in;
  assign xa[0] = x_in;
  assign ya[0] = y_in;
  assign za[0] = z_in;
  assign sa[0] = side_in;

  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    if (k < NSTEP - 1) begin : g_mid
      vsae_cordic_step #(.DW(DW), .IDX(k), .SW(SW)) u_step (
        .clk      (clk),
        .rst_n    (rst_n),
        .v_in     (va[k]),
        .x_in     (xa[k]),
        .y_in     (ya[k]),
        .z_in     (za[k]),
        .side_in  (sa[k]),
        .v_out    (va[k+1]),
        .x_out    (xa[k+1]),
        .y_out    (ya[k+1]),
        .z_out    (za[k+1]),
        .side_out (sa[k+1])
      );
    end else begin : g_last
      // residual y of the last iteration is not needed
      vsae_cordic_step #(.DW(DW), .IDX(k), .SW(SW)) u_step (
        .clk      (clk),
        .rst_n    (rst_n),
        .v_in     (va[k]),
        .x_in     (xa[k]),
        .y_in     (ya[k]),
        .z_in     (za[k]),
        .side_in  (sa[k]),
        .v_out    (va[k+1]),
        .x_out    (xa[k+1]),
        .y_out    (),
        .z_out    (za[k+1]),
        .side_out (sa[k+1])
      );
    end
  end

  assign v_out    = va[NSTEP];
  assign x_out    = xa[NSTEP];
  assign z_out    = za[NSTEP];
  assign side_out = sa[NSTEP];

endmodule

`default_nettype wire

@@ design/vsae_gain.sv @@
// Two-stage CORDIC gain correction: rounded multiply by 1/K in Q32.
`default_nettype none

module vsae_gain import vsae_pkg::*; #(
  parameter int AW = 33,
  parameter int SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          v_in,
  input  wire logic [AW-1:0] a_in,
  input  wire logic [SW-1:0] side_in,
  output logic               v_out,
  output logic [AW-1:0]      p_out,
  output logic [SW-1:0]      side_out
);

  localparam int EW = (AW > 32) ? AW : 33;
  localparam int HW = EW - 32;

  logic [EW-1:0]    a_ext;
  logic [63:0]      lo_prod_nxt;
  logic             v_a_r;
  logic [63:0]      lo_prod_r;
  logic [HW-1:0]    hi_r;
  logic [SW-1:0]    side_a_r;

  logic [HW+31:0]   hi_prod;
  logic [32:0]      lo_rnd;
  logic [HW+32:0]   sum;
  logic             v_b_r;
  logic [AW-1:0]    p_r;
  logic [SW-1:0]    side_b_r;

  // stage A: low 32 bits times 1/K
  always_comb begin
    a_ext       = EW'(a_in);
    lo_prod_nxt = 64'(a_ext[31:0]) * 64'(GAIN_INV);
  end

  // stage B: high bits times 1/K plus rounded low product
  always_comb begin
    hi_prod = (HW+32)'(hi_r) * (HW+32)'(GAIN_INV);
    lo_rnd  = 33'((65'(lo_prod_r) + 65'(GAIN_RND)) >> 32);
    sum     = (HW+33)'(hi_prod) + (HW+33)'(lo_rnd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
    end else begin
      v_a_r <= v_in;
      v_b_r <= v_a_r;
    end
  end

  always_ff @(posedge clk) begin
    lo_prod_r <= lo_prod_nxt;
    hi_r      <= a_ext[EW-1:32];
    side_a_r  <= side_in;
    p_r       <= sum[AW-1:0];
    side_b_r  <= side_a_r;
  end

  assign v_out    = v_b_r;
  assign p_out    = p_r;
  assign side_out = side_b_r;

endmodule

`default_nettype wire

@@ design/velocity_to_speed_azimuth_elevation_top.sv @@
// Top level: velocity vector to speed, azimuth and elevation.
//
// Usage: drive in_vel_east/north/up and pulse start; a beat is taken on any
// clock with start high and busy low. busy is always low, so one vector may
// enter every cycle. Each result appears on out_speed, out_azimuth and
// out_elevation for one cycle with out_valid high; it must be captured then.
//
// The pipeline holds, with N = min(CORDIC_STEPS, 24), one input register,
// N stages for the horizontal pass, two for its gain multiply, N stages for
// the vertical pass, two for its gain multiply and one output register.
// Throughput is one vector per cycle, set by the fully unrolled CORDIC
// stages.
//
// Reset (rst_n low, synchronous) clears all valid bits; beats in flight are
// dropped and no result strobes until new beats arrive. The receiver cannot
// stall, so the pipeline never holds.
`default_nettype none

module velocity_to_speed_azimuth_elevation_top import vsae_pkg::*; #(
  parameter int CORDIC_STEPS = 16,
  parameter int VEL_WIDTH    = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic signed [VEL_WIDTH-1:0] in_vel_east,
  input  wire logic signed [VEL_WIDTH-1:0] in_vel_north,
  input  wire logic signed [VEL_WIDTH-1:0] in_vel_up,
  output logic                             out_valid,
  output logic [SPEED_W-1:0]               out_speed,
  output logic [AZ_W-1:0]                  out_azimuth,
  output logic [EL_W-1:0]                  out_elevation
);

  localparam int NSTEP = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
  localparam int DW    = VEL_WIDTH + FRAC_BITS + 2;
  localparam int AW    = DW - 1;
  localparam int SPW   = (AW - 15 > SPEED_W) ? AW - 15 : SPEED_W + 1;
  localparam int SW1   = DW + 1;
  localparam int SWG1  = DW + AZ_W;
  localparam int SW2   = AZ_W + 1;
  localparam int SWG2  = EL_W + AZ_W;
  localparam logic [AW:0] SPD_HALF = (AW+1)'(32768);

  // ---------------- input register ----------------
  logic                    accept;
  logic signed [DW-1:0]    e_fix, n_fix, u_fix;
  logic signed [DW-1:0]    x0_nxt, y0_nxt, y2_nxt;
  logic signed [ANG_W-1:0] z0_nxt;
  logic                    hz_nxt;
  logic                    s0_v_r;
  logic signed [DW-1:0]    s0_x_r, s0_y_r, s0_y2_r;
  logic signed [ANG_W-1:0] s0_z_r;
  logic                    s0_hz_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    e_fix  = $signed({{(DW-VEL_WIDTH){in_vel_east[VEL_WIDTH-1]}},  in_vel_east})  <<< FRAC_BITS;
    n_fix  = $signed({{(DW-VEL_WIDTH){in_vel_north[VEL_WIDTH-1]}}, in_vel_north}) <<< FRAC_BITS;
    u_fix  = $signed({{(DW-VEL_WIDTH){in_vel_up[VEL_WIDTH-1]}},    in_vel_up})    <<< FRAC_BITS;
    hz_nxt = (in_vel_east == '0) && (in_vel_north == '0);
    // southern half: mirror through the origin and start at 180 degrees
    if (n_fix[DW-1]) begin
      x0_nxt = -n_fix;
      y0_nxt = -e_fix;
      z0_nxt = ANG_180;
    end else begin
      x0_nxt = n_fix;
      y0_nxt = e_fix;
      z0_nxt = '0;
    end
    y2_nxt = u_fix[DW-1] ? -u_fix : u_fix;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else begin
      s0_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s0_x_r  <= x0_nxt;
    s0_y_r  <= y0_nxt;
    s0_z_r  <= z0_nxt;
    s0_y2_r <= y2_nxt;
    s0_hz_r <= hz_nxt;
  end

  // ---------------- horizontal pass ----------------
  logic                    p1_v;
  logic signed [DW-1:0]    p1_x;
  logic signed [ANG_W-1:0] p1_z;
  logic [SW1-1:0]          p1_side;

  vsae_cordic_pass #(.DW(DW), .NSTEP(NSTEP), .SW(SW1)) u_pass_h (
    .clk      (clk),
    .rst_n    (rst_n),
    .v_in     (s0_v_r),
    .x_in     (s0_x_r),
    .y_in     (s0_y_r),
    .z_in     (s0_z_r),
    .side_in  ({s0_hz_r, s0_y2_r}),
    .v_out    (p1_v),
    .x_out    (p1_x),
    .z_out    (p1_z),
    .side_out (p1_side)
  );

  logic                    p1_hz;
  logic [DW-1:0]           p1_y2;
  logic signed [ANG_W-1:0] az_wrap, az_rnd;
  logic [AZ_W-1:0]         az_q, az_val;
  logic [AW-1:0]           g1_a;

  always_comb begin
    p1_hz   = p1_side[DW];
    p1_y2   = p1_side[DW-1:0];
    az_wrap = p1_z[ANG_W-1] ? p1_z + ANG_360 : p1_z;
    if (az_wrap[ANG_W-1]) begin
      az_wrap = '0;
    end
    az_rnd = az_wrap + ANG_HALF;
    az_q   = az_rnd[ANG_SHIFT +: AZ_W];
    // a heading that rounds to a full turn reads as north
    az_val = (az_q >= AZ_FULL) ? az_q - AZ_FULL : az_q;
    if (p1_hz) begin
      az_val = '0;
    end
    g1_a = (p1_hz || p1_x[DW-1]) ? '0 : p1_x[AW-1:0];
  end

  logic            g1_v;
  logic [AW-1:0]   g1_h;
  logic [SWG1-1:0] g1_side;

  vsae_gain #(.AW(AW), .SW(SWG1)) u_gain_h (
    .clk      (clk),
    .rst_n    (rst_n),
    .v_in     (p1_v),
    .a_in     (g1_a),
    .side_in  ({az_val, p1_y2}),
    .v_out    (g1_v),
    .p_out    (g1_h),
    .side_out (g1_side)
  );

  // ---------------- vertical pass ----------------
  logic signed [DW-1:0] x2_in, y2_in;
  logic                 zero2;

  always_comb begin
    x2_in = $signed({1'b0, g1_h});
    y2_in = $signed(g1_side[DW-1:0]);
    zero2 = (g1_h == '0) && (g1_side[DW-1:0] == '0);
  end

  logic                    p2_v;
  logic signed [DW-1:0]    p2_x;
  logic signed [ANG_W-1:0] p2_z;
  logic [SW2-1:0]          p2_side;

  vsae_cordic_pass #(.DW(DW), .NSTEP(NSTEP), .SW(SW2)) u_pass_v (
    .clk      (clk),
    .rst_n    (rst_n),
    .v_in     (g1_v),
    .x_in     (x2_in),
    .y_in     (y2_in),
    .z_in     ('0),
    .side_in  ({zero2, g1_side[SWG1-1:DW]}),
    .v_out    (p2_v),
    .x_out    (p2_x),
    .z_out    (p2_z),
    .side_out (p2_side)
  );

  logic signed [ANG_W-1:0] el_clip, el_rnd;
  logic [SPEED_W-1:0]      el_q;
  logic [EL_W-1:0]         el_val;
  logic [AW-1:0]           g2_a;

  always_comb begin
    el_clip = p2_z[ANG_W-1] ? '0 : p2_z;
    el_rnd  = el_clip + ANG_HALF;
    el_q    = el_rnd[ANG_SHIFT +: SPEED_W];
    el_val  = (el_q > SPEED_W'(EL_MAX)) ? EL_MAX : el_q[EL_W-1:0];
    if (p2_side[AZ_W]) begin
      el_val = '0;
    end
    g2_a = p2_x[DW-1] ? '0 : p2_x[AW-1:0];
  end

  logic            g2_v;
  logic [AW-1:0]   g2_mag;
  logic [SWG2-1:0] g2_side;

  vsae_gain #(.AW(AW), .SW(SWG2)) u_gain_v (
    .clk      (clk),
    .rst_n    (rst_n),
    .v_in     (p2_v),
    .a_in     (g2_a),
    .side_in  ({el_val, p2_side[AZ_W-1:0]}),
    .v_out    (g2_v),
    .p_out    (g2_mag),
    .side_out (g2_side)
  );

  // ---------------- output register ----------------
  logic [AW:0]          spd_sum;
  logic [SPW-1:0]       spd_q;
  logic [SPEED_W-1:0]   speed_nxt;
  logic                 out_valid_r;
  logic [SPEED_W-1:0]   speed_r;
  logic [AZ_W-1:0]      az_r;
  logic [EL_W-1:0]      el_r;

  always_comb begin
    spd_sum   = {1'b0, g2_mag} + SPD_HALF;
    spd_q     = SPW'(spd_sum >> FRAC_BITS);
    speed_nxt = (spd_q > SPW'(SPEED_MAX)) ? SPEED_MAX : spd_q[SPEED_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= g2_v;
    end
  end

  always_ff @(posedge clk) begin
    speed_r <= speed_nxt;
    az_r    <= g2_side[AZ_W-1:0];
    el_r    <= g2_side[SWG2-1:AZ_W];
  end

  assign out_valid     = out_valid_r;
  assign out_speed     = speed_r;
  assign out_azimuth   = az_r;
  assign out_elevation = el_r;

endmodule

`default_nettype wire

@@ test/tb_velocity_to_speed_azimuth_elevation_top.sv @@
// Testbench for the velocity to speed/azimuth/elevation pipeline, checked beat by beat.
`timescale 1ns / 100ps

module tb_velocity_to_speed_azimuth_elevation_top;

  localparam int STEPS     = 16;
  localparam int VW        = 16;
  localparam int LATENCY   = 2 * STEPS + 6;
  localparam int CYCLE_CAP = 200000;
  localparam int N_RANDOM  = 2000;

  // fixed-point scales used by the predictor
  localparam longint UNIT      = 64'sd65536;     // 1.0 in vector fraction bits
  localparam longint DEG       = 64'sd4194304;   // 1 degree in angle units
  localparam longint ANG_RND   = 64'sd32768;     // half an output angle unit
  localparam longint AZ_WRAP   = 64'sd23040;     // 360 degrees, 1/64 degree units
  localparam longint EL_TOP    = 64'sd5760;      // 90 degrees, 1/64 degree units
  localparam longint SPEED_TOP = 64'sd65535;
  localparam bit [63:0] INV_GAIN = 64'd2608131496;

  localparam longint ARCTAN_STEP [24] = '{
    188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
    3754631, 1877430, 938729, 469366, 234683, 117342,
    58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29
  };

  typedef struct packed {
    logic [vsae_pkg::SPEED_W-1:0] speed;
    logic [vsae_pkg::AZ_W-1:0]    azimuth;
    logic [vsae_pkg::EL_W-1:0]    elevation;
  } sph_t;

  typedef struct {
    logic signed [VW-1:0] east;
    logic signed [VW-1:0] north;
    logic signed [VW-1:0] up;
    bit                   known;
    sph_t                 res;
  } vec_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic signed [VW-1:0] in_vel_east;
  logic signed [VW-1:0] in_vel_north;
  logic signed [VW-1:0] in_vel_up;
  logic                 out_valid;
  logic [vsae_pkg::SPEED_W-1:0] out_speed;
  logic [vsae_pkg::AZ_W-1:0]    out_azimuth;
  logic [vsae_pkg::EL_W-1:0]    out_elevation;

  // typed expectation travels with the beat when the row carries one
  bit   beat_known;
  sph_t beat_res;

  sph_t     spherical_due [$];
  sph_t     oldest;
  vec_row_t directed_rows [$];
  int       err_count;
  int       cycle_count;

  velocity_to_speed_azimuth_elevation_top #(
    .CORDIC_STEPS(STEPS),
    .VEL_WIDTH   (VW)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_vel_east  (in_vel_east),
    .in_vel_north (in_vel_north),
    .in_vel_up    (in_vel_up),
    .out_valid    (out_valid),
    .out_speed    (out_speed),
    .out_azimuth  (out_azimuth),
    .out_elevation(out_elevation)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // vectoring pass: drives y toward zero, returns the accumulated angle
  function automatic longint rotate_to_axis(inout longint x, inout longint y);
    longint ang;
    longint xs;
    longint ys;
    ang = 0;
    for (int i = 0; i < STEPS && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x   = x + ys;
        y   = y - xs;
        ang = ang + ARCTAN_STEP[i];
      end else begin
        x   = x - ys;
        y   = y + xs;
        ang = ang - ARCTAN_STEP[i];
      end
    end
    return ang;
  endfunction

  function automatic longint gain_fix(longint a);
    bit [63:0] u;
    bit [63:0] hi;
    bit [63:0] lo;
    bit [63:0] r;
    u  = (a < 0) ? 64'd0 : a;
    hi = u >> 32;
    lo = u & 64'hFFFF_FFFF;
    r  = hi * INV_GAIN + ((lo * INV_GAIN + 64'h8000_0000) >> 32);
    return longint'(r);
  endfunction

  function automatic sph_t spherical_of(logic signed [VW-1:0] e_in,
                                        logic signed [VW-1:0] n_in,
                                        logic signed [VW-1:0] u_in);
    longint e, n, u;
    longint x, y, z, h;
    longint x2, y2, z2;
    longint mag, az, el, spd;
    sph_t   r;
    e  = longint'(e_in);
    n  = longint'(n_in);
    u  = longint'(u_in);
    h  = 0;
    az = 0;
    el = 0;
    if (e != 0 || n != 0) begin
      x = n * UNIT;
      y = e * UNIT;
      z = 0;
      // southern half plane: flip and start from 180 degrees
      if (x < 0) begin
        x = -x;
        y = -y;
        z = 180 * DEG;
      end
      z = z + rotate_to_axis(x, y);
      if (z < 0) z = z + 360 * DEG;
      if (z < 0) z = 0;
      az = (z + ANG_RND) >>> 16;
      while (az >= AZ_WRAP) az = az - AZ_WRAP;
      h = gain_fix(x);
    end
    x2 = h;
    y2 = ((u < 0) ? -u : u) * UNIT;
    if (x2 != 0 || y2 != 0) begin
      z2 = rotate_to_axis(x2, y2);
      if (z2 < 0) z2 = 0;
      el = (z2 + ANG_RND) >>> 16;
      if (el > EL_TOP) el = EL_TOP;
    end
    mag = gain_fix(x2);
    spd = (mag + UNIT / 2) >>> 16;
    if (spd > SPEED_TOP) spd = SPEED_TOP;
    r.speed     = spd[vsae_pkg::SPEED_W-1:0];
    r.azimuth   = az[vsae_pkg::AZ_W-1:0];
    r.elevation = el[vsae_pkg::EL_W-1:0];
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      err_count++;
    end
  endtask

  // result check first, then capture of the input beat taken on this edge
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (out_valid === 1'b1) begin
        if (spherical_due.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %0d/%0d/%0d", $time,
                   out_speed, out_azimuth, out_elevation);
          err_count++;
        end else begin
          oldest = spherical_due.pop_front();
          check_field("speed", int'(oldest.speed), int'(out_speed));
          check_field("azimuth", int'(oldest.azimuth), int'(out_azimuth));
          check_field("elevation", int'(oldest.elevation), int'(out_elevation));
        end
      end else if (out_valid !== 1'b0) begin
        $display("%0t: out_valid unknown, expected 0/1 actual %b", $time, out_valid);
        err_count++;
      end
      if (start === 1'b1 && busy === 1'b0)
        spherical_due.push_back(beat_known ? beat_res :
                                spherical_of(in_vel_east, in_vel_north, in_vel_up));
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_CAP) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_beat(input logic signed [VW-1:0] e, input logic signed [VW-1:0] n,
                           input logic signed [VW-1:0] u, input bit known,
                           input sph_t res, input int gap);
    repeat (gap) begin
      @(negedge clk);
      start        <= 1'b0;
      in_vel_east  <= VW'($urandom());
      in_vel_north <= VW'($urandom());
      in_vel_up    <= VW'($urandom());
    end
    @(negedge clk);
    start        <= 1'b1;
    in_vel_east  <= e;
    in_vel_north <= n;
    in_vel_up    <= u;
    beat_known   <= known;
    beat_res     <= res;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic drain_results;
    @(negedge clk);
    start <= 1'b0;
    while (spherical_due.size() != 0) @(posedge clk);
  endtask

  task automatic add_row(input int e, input int n, input int u);
    vec_row_t r;
    r.east  = VW'(e);
    r.north = VW'(n);
    r.up    = VW'(u);
    r.known = 1'b0;
    r.res   = '0;
    directed_rows.push_back(r);
  endtask

  function automatic logic signed [VW-1:0] pick_component(int kind);
    int extremes [6] = '{-32768, -32767, -1, 0, 1, 32767};
    case (kind)
      0:       return VW'($urandom_range(0, 16) - 8);
      1:       return '0;
      2:       return VW'(extremes[$urandom_range(0, 5)]);
      3:       return VW'($urandom_range(0, 6) - 3);
      default: return VW'($urandom());
    endcase
  endfunction

  initial begin
    vec_row_t  r;
    sph_t      zero_res;
    int        kind;
    int        gap;
    bit        burst;
    logic signed [VW-1:0] e, n, u;

    err_count    = 0;
    cycle_count  = 0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_vel_east  = '0;
    in_vel_north = '0;
    in_vel_up    = '0;
    beat_known   = 1'b0;
    beat_res     = '0;
    zero_res     = '0;

    // zero vector gives all zeros
    r.east = 0; r.north = 0; r.up = 0; r.known = 1'b1; r.res = zero_res;
    directed_rows.push_back(r);
    add_row(32767, 0, 0);
    add_row(-32768, 0, 0);
    add_row(0, 32767, 0);
    add_row(0, -32768, 0);
    add_row(0, 0, 32767);         // no horizontal part: azimuth 0, elevation near 90
    add_row(0, 0, -32768);
    add_row(-32768, -32768, -32768);
    add_row(32767, 32767, 32767);
    add_row(-32768, 32767, -1);
    add_row(1, 0, 0);
    add_row(0, 1, 0);
    add_row(0, 0, 1);
    add_row(-1, -1, -1);
    add_row(0, -1, 0);            // south: flipped, 180 added
    add_row(-1, 0, 0);            // negative angle gets 360 added
    add_row(-1, 32767, 0);        // just west of north: rounds to 360, wraps to 0
    add_row(1, -32768, 5);
    add_row(-1, -32768, 0);
    add_row(0, 0, 100);
    add_row(12345, -23456, 7);
    add_row(3, 4, -12);
    add_row(21845, -21846, 10922);
    directed_rows.push_back(r);   // zero vector again, mid stream

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_beat(directed_rows[i].east, directed_rows[i].north, directed_rows[i].up,
                directed_rows[i].known, directed_rows[i].res, $urandom_range(0, 2));
    drain_results();

    burst = 1'b0;
    for (int k = 0; k < N_RANDOM; k++) begin
      if (k % 40 == 0) burst = ($urandom_range(0, 3) == 0);
      if (k % 500 == 499) drain_results();
      kind = $urandom_range(0, 9);
      case (kind)
        4: begin
          e = pick_component(0); n = pick_component(0); u = pick_component(0);
        end
        5: begin
          e = pick_component($urandom_range(0, 1) ? 1 : 4);
          n = pick_component($urandom_range(0, 1) ? 1 : 4);
          u = pick_component($urandom_range(0, 1) ? 1 : 4);
        end
        6: begin
          e = pick_component(2); n = pick_component(2); u = pick_component(2);
        end
        7: begin
          // near due south
          e = pick_component(3); n = -VW'($urandom_range(1, 32768)); u = pick_component(4);
        end
        8: begin
          // just west of north, azimuth close to 360
          e = -VW'($urandom_range(0, 8)); n = VW'($urandom_range(1, 32767));
          u = pick_component(4);
        end
        9: begin
          // steep: tiny horizontal, large vertical
          e = pick_component(3); n = pick_component(3); u = pick_component(4);
        end
        default: begin
          e = pick_component(4); n = pick_component(4); u = pick_component(4);
        end
      endcase
      gap = burst ? 0 : $urandom_range(0, 9);
      send_beat(e, n, u, 1'b0, zero_res, gap);
    end

    drain_results();
    repeat (2 * LATENCY) @(posedge clk);

    if (err_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ sim.f @@
design/vsae_pkg.sv
design/vsae_cordic_step.sv
design/vsae_cordic_pass.sv
design/vsae_gain.sv
design/velocity_to_speed_azimuth_elevation_top.sv
test/tb_velocity_to_speed_azimuth_elevation_top.sv
